// ===== hdl/wcpa_pkg.sv =====
`default_nettype none

package wcpa_pkg;

   // number of station slots carried in the request and response
   localparam int NSLOT = 3;

   // field widths
   localparam int RAW_W = 10;
   localparam int CHG_W = 7;
   localparam int PWR_W = 11;
   localparam int AVL_W = 12;
   localparam int MSK_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 12;

   // stream widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   // serial arithmetic widths
   localparam int MUL_AW = 12;
   localparam int MUL_BW = 11;
   localparam int PROD_W = 21;
   localparam int DIV_VW = 10;
   localparam int TOT_W = 9;

   // arithmetic constants
   localparam logic [CHG_W-1:0] PRIORITY_BASE = 7'd101;
   localparam logic [CHG_W-1:0] CHARGE_MAX = 7'd100;
   localparam logic [RAW_W-1:0] RAW_FULL = 10'd1023;

   // register reset values
   localparam logic [PWR_W-1:0] GRID_RST = 11'd600;
   localparam logic [PWR_W-1:0] SOLAR_RST = 11'd400;
   localparam logic [AVL_W-1:0] SYSMAX_RST = 12'd1000;
   localparam logic [PWR_W-1:0] STNMAX_RST = 11'd500;
   localparam logic [CHG_W-1:0] FULL_RST = 7'd95;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID   = 3'd0,
      CSR_SOLAR  = 3'd1,
      CSR_SYSMAX = 3'd2,
      CSR_STNMAX = 3'd3,
      CSR_FULL   = 3'd4
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SOL_MUL,
      ST_SOL_DIV,
      ST_PASS,
      ST_PICK,
      ST_SHR_MUL,
      ST_SHR_DIV,
      ST_FINISH
   } state_type;

   // charge saturated to full scale
   function automatic logic [CHG_W-1:0] sat_charge(input logic [CHG_W-1:0] c);
      sat_charge = (c > CHARGE_MAX) ? CHARGE_MAX : c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/weighted_capped_power_allocator.sv =====
// Weighted capped power allocator. Each request carries one light reading, the charge
// of three stations, a connected mask and a temperature alarm; each request yields one
// response with the grant of every station, the solar power and the available power.
// All arithmetic runs on one bit-serial shift-add multiplier and one restoring
// divider. A request computes the solar figure first, by a multiply and a divide;
// then each sharing pass visits the station slots in turn, computing the share of
// every eligible station by a multiply and a divide, for at most three passes. The
// request side is ready only while the sequencer is idle; a finished response waits
// in its own register, so the next request can be taken while the response is still
// held. The user must write registers through the csr port only while no request is
// in work; the block itself does not enforce it.
`default_nettype none

module weighted_capped_power_allocator #(
   parameter int STATIONS = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: solar_raw, charge_0, charge_1, charge_2, connected_mask,
   //          over_temperature, zero pad
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [wcpa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response: power_0, power_1, power_2, solar_power, available_power
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [wcpa_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // register writes
   input  wire logic                              csr_wen,
   input  wire logic [wcpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [wcpa_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import wcpa_pkg::*;

   localparam int PASS_W = $clog2(STATIONS + 1);
   localparam int IDX_W = $clog2(NSLOT + 1);

   // registers
   logic [PWR_W-1:0] grid_ff, solar_max_ff, stnmax_ff;
   logic [AVL_W-1:0] sysmax_ff;
   logic [CHG_W-1:0] full_ff;

   // request fields
   logic [RAW_W-1:0] req_raw;
   logic [CHG_W-1:0] req_chg [NSLOT];
   logic [MSK_W-1:0] req_mask;
   logic             req_alarm;

   // work state
   state_type        state_ff, state_in;
   logic [CHG_W-1:0] lvl_ff [NSLOT], lvl_in [NSLOT];
   logic [MSK_W-1:0] mask_ff, mask_in;
   logic             alarm_ff, alarm_in;
   logic [PWR_W-1:0] grant_ff [NSLOT], grant_in [NSLOT];
   logic [AVL_W-1:0] remaining_ff, remaining_in;
   logic [AVL_W-1:0] start_ff, start_in;
   logic [PWR_W-1:0] solar_ff, solar_in;
   logic [AVL_W-1:0] avail_ff, avail_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic             assigned_ff, assigned_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // arithmetic units
   logic                 mul_start, mul_done;
   logic [MUL_AW-1:0]    mul_a;
   logic [MUL_BW-1:0]    mul_b;
   logic [PROD_W-1:0]    mul_product;
   logic                 div_start, div_done;
   logic [DIV_VW-1:0]    div_divisor;
   logic [PROD_W-1:0]    div_quotient;

   // eligibility and weights
   logic [NSLOT-1:0] elig;
   logic [CHG_W-1:0] weight [NSLOT];
   logic [TOT_W-1:0] total_sum;
   logic             sel_elig;
   logic [CHG_W-1:0] sel_weight;
   logic [PWR_W-1:0] sel_grant;

   // share and totals
   logic [PROD_W-1:0] share_lo, share_room, share_fin;
   logic [PWR_W-1:0]  room;
   logic [AVL_W-1:0]  grid_solar;
   logic [PWR_W-1:0]  solar_val;
   logic [PASS_W-1:0] pass_next;

   // request unpacking
   assign req_raw    = req_tdata[9:0];
   assign req_chg[0] = req_tdata[16:10];
   assign req_chg[1] = req_tdata[23:17];
   assign req_chg[2] = req_tdata[30:24];
   assign req_mask   = req_tdata[33:31];
   assign req_alarm  = req_tdata[34];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff      <= GRID_RST;
         solar_max_ff <= SOLAR_RST;
         sysmax_ff    <= SYSMAX_RST;
         stnmax_ff    <= STNMAX_RST;
         full_ff      <= FULL_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_GRID:   grid_ff      <= csr_wdata[PWR_W-1:0];
            CSR_SOLAR:  solar_max_ff <= csr_wdata[PWR_W-1:0];
            CSR_SYSMAX: sysmax_ff    <= csr_wdata[AVL_W-1:0];
            CSR_STNMAX: stnmax_ff    <= csr_wdata[PWR_W-1:0];
            CSR_FULL:   full_ff      <= csr_wdata[CHG_W-1:0];
            default:    ;
         endcase
      end
   end

   // station eligibility, weights and their sum
   always_comb begin
      total_sum  = '0;
      sel_elig   = 1'b0;
      sel_weight = '0;
      sel_grant  = '0;
      for (int i = 0; i < NSLOT; i++) begin
         elig[i]   = (i < STATIONS) && mask_ff[i] && (lvl_ff[i] < full_ff)
                     && (grant_ff[i] < stnmax_ff);
         weight[i] = PRIORITY_BASE - lvl_ff[i];
         if (elig[i]) begin
            total_sum = total_sum + TOT_W'(weight[i]);
         end
         if (idx_ff == IDX_W'(i)) begin
            sel_elig   = elig[i];
            sel_weight = weight[i];
            sel_grant  = grant_ff[i];
         end
      end
   end

   // share clamps: at least one, then headroom, then what remains
   always_comb begin
      room       = stnmax_ff - sel_grant;
      share_lo   = (div_quotient == '0) ? PROD_W'(1) : div_quotient;
      share_room = (share_lo > PROD_W'(room)) ? PROD_W'(room) : share_lo;
      share_fin  = (share_room > PROD_W'(remaining_ff)) ? PROD_W'(remaining_ff)
                                                          : share_room;
   end

   // solar clamp and available power
   always_comb begin
      solar_val  = (div_quotient > PROD_W'(solar_max_ff)) ? solar_max_ff
                                                          : div_quotient[PWR_W-1:0];
      grid_solar = AVL_W'(grid_ff) + AVL_W'(solar_val);
   end

   assign pass_next = pass_ff + 1'b1;

   // unit operands
   assign mul_a       = (state_ff == ST_IDLE) ? MUL_AW'(RAW_FULL - req_raw) : start_ff;
   assign mul_b       = (state_ff == ST_IDLE) ? solar_max_ff : MUL_BW'(sel_weight);
   assign div_divisor = (state_ff == ST_SOL_MUL) ? RAW_FULL : DIV_VW'(total_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      mask_in      = mask_ff;
      alarm_in     = alarm_ff;
      grant_in     = grant_ff;
      remaining_in = remaining_ff;
      start_in     = start_ff;
      solar_in     = solar_ff;
      avail_in     = avail_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      assigned_in  = assigned_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               for (int i = 0; i < NSLOT; i++) begin
                  lvl_in[i] = sat_charge(req_chg[i]);
               end
               mask_in   = req_mask;
               alarm_in  = req_alarm;
               mul_start = 1'b1;
               state_in  = ST_SOL_MUL;
            end
         end
         ST_SOL_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_SOL_DIV;
            end
         end
         ST_SOL_DIV: begin
            if (div_done) begin
               solar_in     = solar_val;
               avail_in     = (grid_solar > sysmax_ff) ? sysmax_ff : grid_solar;
               remaining_in = avail_in;
               for (int i = 0; i < NSLOT; i++) begin
                  grant_in[i] = '0;
               end
               pass_in  = '0;
               state_in = (alarm_ff || avail_in == '0) ? ST_FINISH : ST_PASS;
            end
         end
         ST_PASS: begin
            if (total_sum == '0) begin
               state_in = ST_FINISH;
            end else begin
               total_in    = total_sum;
               start_in    = remaining_ff;
               assigned_in = 1'b0;
               idx_in      = '0;
               state_in    = ST_PICK;
            end
         end
         ST_PICK: begin
            if (idx_ff == IDX_W'(NSLOT)) begin
               pass_in = pass_next;
               if (!assigned_ff || pass_next == PASS_W'(STATIONS)
                   || remaining_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PASS;
               end
            end else if (sel_elig) begin
               mul_start = 1'b1;
               state_in  = ST_SHR_MUL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SHR_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_SHR_DIV;
            end
         end
         ST_SHR_DIV: begin
            if (div_done) begin
               for (int i = 0; i < NSLOT; i++) begin
                  if (idx_ff == IDX_W'(i)) begin
                     grant_in[i] = grant_ff[i] + share_fin[PWR_W-1:0];
                  end
               end
               remaining_in = remaining_ff - share_fin[AVL_W-1:0];
               if (share_fin != '0) begin
                  assigned_in = 1'b1;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_FINISH: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {avail_ff, solar_ff, grant_ff[2], grant_ff[1], grant_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      lvl_ff       <= lvl_in;
      mask_ff      <= mask_in;
      alarm_ff     <= alarm_in;
      grant_ff     <= grant_in;
      remaining_ff <= remaining_in;
      start_ff     <= start_in;
      solar_ff     <= solar_in;
      avail_ff     <= avail_in;
      total_ff     <= total_in;
      idx_ff       <= idx_in;
      pass_ff      <= pass_in;
      assigned_ff  <= assigned_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // serial multiplier
   wcpa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   // serial divider
   wcpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/wcpa_mul.sv =====
`default_nettype none

module wcpa_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [wcpa_pkg::MUL_AW-1:0]   a,
   input  wire logic [wcpa_pkg::MUL_BW-1:0]   b,
   output logic                               done,
   output logic [wcpa_pkg::PROD_W-1:0]        product
);
   import wcpa_pkg::*;

   localparam int CNT_W = $clog2(MUL_BW);

   logic [MUL_AW-1:0] a_ff, a_in;
   logic [MUL_AW-1:0] hi_ff, hi_in;
   logic [MUL_BW-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MUL_AW:0]   sum;
   logic [MUL_AW-1:0] addend;
   logic [MUL_AW+MUL_BW-1:0] full;

   // one multiplier bit per cycle, shift-add from the low end
   always_comb begin
      addend  = lo_ff[0] ? a_ff : '0;
      sum     = {1'b0, hi_ff} + {1'b0, addend};
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_AW:1];
         lo_in  = {sum[0], lo_ff[MUL_BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

   assign full    = {hi_ff, lo_ff};
   assign product = full[PROD_W-1:0];
   assign done    = done_ff;

endmodule

`default_nettype wire

// ===== hdl/wcpa_div.sv =====
`default_nettype none

module wcpa_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [wcpa_pkg::PROD_W-1:0]   dividend,
   input  wire logic [wcpa_pkg::DIV_VW-1:0]   divisor,
   output logic                               done,
   output logic [wcpa_pkg::PROD_W-1:0]        quotient
);
   import wcpa_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic [DIV_VW-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DIV_VW-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_VW:0]   trial;
   logic [DIV_VW:0]   diff;
   logic              ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
         quo_in = {quo_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== tb/tb_weighted_capped_power_allocator.sv =====
`timescale 1ns / 100ps

module tb_weighted_capped_power_allocator;
   import wcpa_pkg::*;

   localparam int STATIONS = 3;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int END_WAIT = 400;
   localparam int SETTLE = 4;
   localparam int MAX_PRINTED = 40;

   // request layout, lowest bits first: solar_raw, charge_0..2, connected_mask,
   // over_temperature
   typedef struct packed {
      logic                            over_temp;
      logic [MSK_W-1:0]                connected;
      logic [NSLOT-1:0][CHG_W-1:0]     charge;
      logic [RAW_W-1:0]                solar_raw;
   } charge_request_type;

   // response layout, lowest bits first: power_0..2, solar_power, available_power
   typedef struct packed {
      logic [AVL_W-1:0]                avail;
      logic [PWR_W-1:0]                solar;
      logic [NSLOT-1:0][PWR_W-1:0]     grant;
   } grant_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // solar_raw, charge_0, charge_1, charge_2, connected_mask, over_temperature, pad
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // power_0, power_1, power_2, solar_power, available_power
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DAT_W-1:0]    csr_wdata = '0;

   // register copies used by the grant predictor
   logic [PWR_W-1:0]        cfg_grid = GRID_RST;
   logic [PWR_W-1:0]        cfg_solar = SOLAR_RST;
   logic [AVL_W-1:0]        cfg_sysmax = SYSMAX_RST;
   logic [PWR_W-1:0]        cfg_stnmax = STNMAX_RST;
   logic [CHG_W-1:0]        cfg_full = FULL_RST;

   grant_result_type        expected_grants[$];
   bit                      no_idle = 1'b0;
   int unsigned             cycle_count = 0;
   int unsigned             mismatches = 0;
   int unsigned             requests_sent = 0;
   int unsigned             alarm_requests = 0;
   int unsigned             results_checked = 0;
   int unsigned             settings_used = 0;

   weighted_capped_power_allocator #(.STATIONS(STATIONS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d predictions pending", cycle_count,
                  expected_grants.size());
         $display("tb_weighted_capped_power_allocator: errors");
         $finish;
      end
   end

   // station can still take power in this pass
   function automatic bit wants_power(input int i, input int unsigned lvl [NSLOT],
                                      input int unsigned given [NSLOT],
                                      input logic [MSK_W-1:0] mask);
      if (i >= STATIONS) return 1'b0;
      if (!mask[i]) return 1'b0;
      if (lvl[i] >= 32'(cfg_full)) return 1'b0;
      return given[i] < 32'(cfg_stnmax);
   endfunction

   // solar, available power and weighted capped grants for one request
   function automatic grant_result_type predict_grants(input charge_request_type rq);
      grant_result_type res;
      int unsigned lvl [NSLOT];
      int unsigned given [NSLOT];
      int unsigned raw, solar, avail, remaining, total, start, assigned, share, room;
      int unsigned base, full_raw;
      base = 32'(PRIORITY_BASE);
      full_raw = 32'(RAW_FULL);
      for (int i = 0; i < NSLOT; i++) begin
         lvl[i] = 32'((rq.charge[i] > CHARGE_MAX) ? CHARGE_MAX : rq.charge[i]);
         given[i] = 0;
      end
      raw = 32'(rq.solar_raw);
      solar = (full_raw - raw) * 32'(cfg_solar) / full_raw;
      if (solar > 32'(cfg_solar)) solar = 32'(cfg_solar);
      avail = 32'(cfg_grid) + solar;
      if (avail > 32'(cfg_sysmax)) avail = 32'(cfg_sysmax);
      remaining = avail;
      // sharing passes, skipped entirely under the temperature alarm
      if (!rq.over_temp) begin
         for (int pass = 0; pass < STATIONS && remaining > 0; pass++) begin
            total = 0;
            for (int i = 0; i < NSLOT; i++)
               if (wants_power(i, lvl, given, rq.connected)) total += base - lvl[i];
            if (total == 0) break;
            start = remaining;
            assigned = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (wants_power(i, lvl, given, rq.connected)) begin
                  share = start * (base - lvl[i]) / total;
                  if (share < 1) share = 1;
                  room = 32'(cfg_stnmax) - given[i];
                  if (share > room) share = room;
                  if (share > remaining) share = remaining;
                  given[i] += share;
                  remaining -= share;
                  assigned += share;
               end
            end
            if (assigned == 0) break;
         end
      end
      for (int i = 0; i < NSLOT; i++) res.grant[i] = given[i][PWR_W-1:0];
      res.solar = solar[PWR_W-1:0];
      res.avail = avail[AVL_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch on %s at cycle %0d: got %0d, expected %0d", field, cycle_count,
                  got, want);
   endtask

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin : response_check
      grant_result_type got;
      grant_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_grants.size() == 0) begin
            report_mismatch("response with nothing pending", 1, 0);
         end else begin
            want = expected_grants.pop_front();
            for (int i = 0; i < NSLOT; i++)
               if (got.grant[i] !== want.grant[i])
                  report_mismatch($sformatf("power_%0d", i), 32'(got.grant[i]),
                                  32'(want.grant[i]));
            if (got.solar !== want.solar)
               report_mismatch("solar_power", 32'(got.solar), 32'(want.solar));
            if (got.avail !== want.avail)
               report_mismatch("available_power", 32'(got.avail), 32'(want.avail));
            results_checked++;
         end
      end
   end

   // response side: random stall before each response
   initial begin : response_sink
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   // one request, with a random gap in front; valid stays up across a zero gap
   task automatic send_request(input charge_request_type rq);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - $bits(charge_request_type)){1'b0}}, rq};
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_grants.push_back(predict_grants(rq));
      requests_sent++;
      if (rq.over_temp) alarm_requests++;
   endtask

   // stop sending and let every pending response come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register write; the caller lowers the enable after the last one
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_GRID:   cfg_grid = value[PWR_W-1:0];
         CSR_SOLAR:  cfg_solar = value[PWR_W-1:0];
         CSR_SYSMAX: cfg_sysmax = value[AVL_W-1:0];
         CSR_STNMAX: cfg_stnmax = value[PWR_W-1:0];
         CSR_FULL:   cfg_full = value[CHG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DAT_W-1:0] grid, input logic [CSR_DAT_W-1:0] solar,
                             input logic [CSR_DAT_W-1:0] sysmax,
                             input logic [CSR_DAT_W-1:0] stnmax,
                             input logic [CSR_DAT_W-1:0] full);
      wait_idle();
      write_reg(CSR_GRID, grid);
      write_reg(CSR_SOLAR, solar);
      write_reg(CSR_SYSMAX, sysmax);
      write_reg(CSR_STNMAX, stnmax);
      write_reg(CSR_FULL, full);
      csr_wen <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic charge_request_type compose_request(input int raw, input int c0,
                                                          input int c1, input int c2,
                                                          input int mask, input int alarm);
      charge_request_type rq;
      rq.solar_raw = raw[RAW_W-1:0];
      rq.charge[0] = c0[CHG_W-1:0];
      rq.charge[1] = c1[CHG_W-1:0];
      rq.charge[2] = c2[CHG_W-1:0];
      rq.connected = mask[MSK_W-1:0];
      rq.over_temp = alarm[0];
      return rq;
   endfunction

   // mostly plausible ticks, with extremes, saturated and near-threshold charges
   function automatic charge_request_type random_request();
      charge_request_type rq;
      int near;
      case ($urandom_range(0, 7))
         0:       rq.solar_raw = '0;
         1:       rq.solar_raw = '1;
         default: rq.solar_raw = RAW_W'($urandom_range(0, 1023));
      endcase
      for (int i = 0; i < NSLOT; i++) begin
         case ($urandom_range(0, 15))
            0:       rq.charge[i] = '0;
            1:       rq.charge[i] = CHARGE_MAX;
            2:       rq.charge[i] = CHG_W'($urandom_range(101, 127));
            3: begin
               near = int'(cfg_full) + int'($urandom_range(0, 2)) - 1;
               if (near < 0) near = 0;
               if (near > 127) near = 127;
               rq.charge[i] = near[CHG_W-1:0];
            end
            default: rq.charge[i] = CHG_W'($urandom_range(0, 100));
         endcase
      end
      rq.connected = ($urandom_range(0, 2) == 0) ? '1 : MSK_W'($urandom_range(0, 7));
      rq.over_temp = ($urandom_range(0, 7) == 0);
      return rq;
   endfunction

   // reset register values: light extremes, alarm, masks, thresholds, saturation
   task automatic test_reset_values();
      send_request(compose_request(0, 0, 0, 0, 7, 0));
      send_request(compose_request(1023, 100, 100, 100, 7, 0));
      send_request(compose_request(512, 10, 20, 30, 7, 1));
      send_request(compose_request(300, 10, 20, 30, 0, 0));
      send_request(compose_request(0, 94, 95, 96, 7, 0));
      send_request(compose_request(0, 127, 101, 50, 7, 0));
      send_request(compose_request(200, 0, 50, 100, 1, 0));
      send_request(compose_request(200, 0, 50, 100, 2, 0));
      send_request(compose_request(200, 0, 50, 100, 4, 0));
   endtask

   // all registers at zero, then at their maximum (full threshold at 101), plus ignored and oversized writes
   task automatic test_register_extremes();
      set_config(0, 0, 0, 0, 0);
      send_request(compose_request(0, 0, 0, 0, 7, 0));
      send_request(compose_request(1023, 100, 50, 0, 7, 1));
      set_config(2047, 2047, 4095, 2047, 101);
      write_reg(3'd5, 12'hABC);
      write_reg(3'd6, 12'h000);
      write_reg(3'd7, 12'hFFF);
      write_reg(CSR_GRID, 12'hFFF);
      csr_wen <= 1'b0;
      send_request(compose_request(0, 127, 127, 127, 7, 0));
      send_request(compose_request(0, 0, 0, 0, 7, 0));
      send_request(compose_request(1023, 0, 100, 127, 7, 0));
   endtask

   // per-station caps, a second sharing pass, and the minimum share of one watt
   task automatic test_station_caps();
      set_config(600, 400, 4095, 1, 95);
      send_request(compose_request(0, 0, 0, 0, 7, 0));
      set_config(1000, 0, 4095, 300, 95);
      send_request(compose_request(0, 0, 90, 90, 7, 0));
      send_request(compose_request(700, 0, 0, 0, 3, 0));
      set_config(2, 0, 4095, 300, 95);
      send_request(compose_request(0, 0, 94, 94, 7, 0));
   endtask

   // random register settings, each followed by a run of random ticks
   task automatic test_random_ticks();
      logic [CSR_DAT_W-1:0] grid, solar, sysmax, stnmax, full;
      for (int phase = 0; phase < 8; phase++) begin
         grid = ($urandom_range(0, 3) == 0) ? CSR_DAT_W'($urandom_range(0, 50))
                                           : CSR_DAT_W'($urandom_range(0, 2047));
         solar = CSR_DAT_W'($urandom_range(0, 2047));
         sysmax = CSR_DAT_W'($urandom_range(0, 4095));
         case ($urandom_range(0, 2))
            0:       stnmax = CSR_DAT_W'($urandom_range(1, 40));
            1:       stnmax = CSR_DAT_W'($urandom_range(41, 600));
            default: stnmax = CSR_DAT_W'($urandom_range(0, 2047));
         endcase
         full = ($urandom_range(0, 3) == 0) ? CSR_DAT_W'($urandom_range(0, 101))
                                           : CSR_DAT_W'($urandom_range(60, 101));
         set_config(grid, solar, sysmax, stnmax, full);
         no_idle = (phase == 3 || phase == 6);
         for (int n = 0; n < 135; n++) begin
            // hold off until the block has drained completely
            if (phase == 2 && n == 60) wait_idle();
            send_request(random_request());
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_register_extremes();
      test_station_caps();
      test_random_ticks();
      wait_idle();
      repeat (END_WAIT) @(posedge clock);
      $display("run covered %0d control ticks (%0d under temperature alarm), %0d responses",
               requests_sent, alarm_requests, results_checked);
      $display("across %0d register settings, %0d mismatches", settings_used, mismatches);
      if (mismatches == 0) begin
         $display("tb_weighted_capped_power_allocator: clean");
      end else begin
         $display("tb_weighted_capped_power_allocator: errors");
      end
      $finish;
   end

endmodule
